// ===== src/priority_interrupt_controller_core_defines.svh =====
// assertion helpers for the interrupt controller
`ifndef PRIORITY_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define PIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pic_pkg.sv =====
package pic_pkg;

    localparam logic [2:0] CMD_LINE  = 3'd0;
    localparam logic [2:0] CMD_ACK   = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_SETUP = 3'd4;

    localparam logic [1:0] MODE_LEVEL = 2'd0;
    localparam logic [1:0] MODE_FALL  = 2'd1;
    localparam logic [1:0] MODE_RISE  = 2'd2;
    localparam logic [1:0] MODE_BOTH  = 2'd3;

    localparam logic [10:0] ADDR_TE_BASE     = 11'h100;
    localparam logic [10:0] ADDR_EN_BASE     = 11'h200;
    localparam logic [10:0] ADDR_EN_LAST     = 11'h21f;
    localparam logic [10:0] ADDR_SWI         = 11'h2e0;
    localparam logic [10:0] ADDR_FAST_VEC    = 11'h2f0;
    localparam logic [10:0] ADDR_PRI_BASE    = 11'h300;
    localparam logic [10:0] ADDR_PRI_LAST    = 11'h38f;
    localparam logic [10:0] ADDR_DMA0        = 11'h400;
    localparam logic [10:0] ADDR_DMA1        = 11'h404;
    localparam logic [10:0] ADDR_DMA2        = 11'h408;
    localparam logic [10:0] ADDR_DMA3        = 11'h40c;
    localparam logic [10:0] ADDR_SENSE_BASE  = 11'h500;
    localparam logic [10:0] ADDR_SENSE_LAST  = 11'h51f;
    localparam logic [10:0] ADDR_NMI_STAT    = 11'h580;
    localparam logic [10:0] ADDR_NMI_EN      = 11'h581;
    localparam logic [10:0] ADDR_NMI_RSV     = 11'h582;
    localparam logic [10:0] ADDR_NMI_MODE    = 11'h583;

    localparam logic [8:0] SENSE_SRC_OFFSET = 9'd64;

    typedef struct packed {
        logic       pending;
        logic [7:0] slot;
        logic [1:0] sense;
        logic       last;
        logic       te;
    } t_src_entry;

    localparam t_src_entry SRC_RESET = '{pending: 1'b0, slot: 8'd0, sense: MODE_RISE,
                                         last: 1'b0, te: 1'b0};

endpackage

// ===== src/priority_interrupt_controller_core.sv =====
// Interrupt controller core: one command is taken when start is high and busy is low, and
// exactly one result follows as a one-cycle o_valid strobe that the receiver must take as
// it comes. Per-source state (pending, slot, trigger mode, last level, transfer enable) sits
// in one synchronous memory and the priority registers in a second; each command does a
// read-modify-write over them. After reset the block stays busy while it writes reset values
// into every entry of both memories. Line changes, setups and bus accesses go from accept
// through the read state to the registered strobe; a line change that raises a request
// passes a second read state too, since the priority read follows the source read. An
// acknowledge with a request outstanding scans every source through both memories one per
// cycle and answers from a final state; without a request it answers from the read state.
module priority_interrupt_controller_core #(
    parameter int NUM_SOURCES       = 256,
    parameter int NUM_PRIORITY_REGS = 144
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_irq_number,
    input  logic        i_line_level,
    input  logic [10:0] i_address,
    input  logic [1:0]  i_access_size,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_priority_slot,
    input  logic        i_level_triggered,
    output logic        o_valid,
    output logic        o_line_update,
    output logic        o_line_select,
    output logic [11:0] o_line_value,
    output logic        o_soft_pulse,
    output logic [15:0] o_read_data,
    output logic        o_access_error
);
    import pic_pkg::*;

    `include "priority_interrupt_controller_core_defines.svh"

    localparam int SW = $clog2(NUM_SOURCES);
    localparam int PW = (NUM_PRIORITY_REGS > 1) ? $clog2(NUM_PRIORITY_REGS) : 1;
    localparam int CLR_N = (NUM_SOURCES > NUM_PRIORITY_REGS) ? NUM_SOURCES : NUM_PRIORITY_REGS;
    localparam int CW = $clog2(CLR_N) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD1  = 3'd1;
    localparam logic [2:0] ST_RD2  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_CLR  = 3'd5;

    // memories
    t_src_entry src_mem [NUM_SOURCES];
    logic [3:0] prio_mem [NUM_PRIORITY_REGS];

    t_src_entry r_src_q;
    logic [3:0] r_prio_q;

    logic          src_we;
    logic [SW-1:0] src_wa, src_ra;
    t_src_entry    src_wd;
    logic          prio_we;
    logic [PW-1:0] prio_wa, prio_ra;
    logic [3:0]    prio_wd;

    // control and latched command
    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_clr_idx, n_clr_idx;
    logic [2:0]  r_cmd, n_cmd;
    logic [7:0]  r_n, n_n;
    logic        r_lvl, n_lvl;
    logic [10:0] r_addr, n_addr;
    logic [1:0]  r_size, n_size;
    logic [15:0] r_wdata, n_wdata;
    logic [7:0]  r_slot, n_slot;
    logic        r_lt, n_lt;
    logic [8:0]  r_sidx, n_sidx;
    logic        r_pslot_ok, n_pslot_ok;

    logic        r_req_valid, n_req_valid;
    logic [7:0]  r_cur, n_cur;
    logic        r_fv_en, n_fv_en;
    logic [7:0]  r_fv_lo, n_fv_lo;
    logic [2:0]  r_nmi_en, n_nmi_en;
    logic        r_nmi_mode, n_nmi_mode;
    logic [7:0]  r_dma [4];
    logic [7:0]  n_dma [4];
    logic [7:0]  r_en [32];
    logic [7:0]  n_en [32];

    // scan pipeline
    logic [SW:0]   r_scan_idx, n_scan_idx;
    logic          r_a_vld, n_a_vld;
    logic [SW-1:0] r_a_idx, n_a_idx;
    logic          r_b_vld, n_b_vld;
    logic [SW-1:0] r_b_idx, n_b_idx;
    logic [3:0]    r_best, n_best;
    logic [SW-1:0] r_best_n, n_best_n;

    logic        r_o_valid, n_o_valid;
    logic        r_o_upd, n_o_upd;
    logic        r_o_sel, n_o_sel;
    logic [11:0] r_o_val, n_o_val;
    logic        r_o_pulse, n_o_pulse;
    logic [15:0] r_o_rd, n_o_rd;
    logic        r_o_err, n_o_err;

    t_src_entry se;
    logic [3:0] pe;
    logic [7:0] en_src;
    logic [4:0] en_row;
    logic [7:0] en_byte;
    logic       en_bit;
    logic       is_bus;

    always_comb begin
        se = r_src_q;
        pe = r_prio_q;
        is_bus = (r_cmd == CMD_READ) || (r_cmd == CMD_WRITE);
        en_src = (r_state == ST_FIN) ? 8'(r_best_n) : r_n;
        en_row = is_bus ? r_addr[4:0] : en_src[7:3];
        en_byte = r_en[en_row];
        en_bit = en_byte[en_src[2:0]];
    end

    function automatic logic fast_sel(input logic fv_en, input logic [7:0] fv_lo,
                                      input logic [7:0] src);
        return fv_en && (fv_lo == src);
    endfunction

    always_comb begin
        logic       done;
        logic       upd, sel, pulse, err, issue, wr, size_bad;
        logic [11:0] val;
        logic [15:0] rd;
        logic [8:0] sidx;
        logic       n_ok, sidx_ok;
        logic [7:0] b;
        t_src_entry wd;

        n_state = r_state;
        n_clr_idx = r_clr_idx;
        n_cmd = r_cmd;
        n_n = r_n;
        n_lvl = r_lvl;
        n_addr = r_addr;
        n_size = r_size;
        n_wdata = r_wdata;
        n_slot = r_slot;
        n_lt = r_lt;
        n_sidx = r_sidx;
        n_pslot_ok = r_pslot_ok;
        n_req_valid = r_req_valid;
        n_cur = r_cur;
        n_fv_en = r_fv_en;
        n_fv_lo = r_fv_lo;
        n_nmi_en = r_nmi_en;
        n_nmi_mode = r_nmi_mode;
        n_dma = r_dma;
        n_en = r_en;
        n_scan_idx = r_scan_idx;
        n_a_vld = 1'b0;
        n_a_idx = r_a_idx;
        n_b_vld = 1'b0;
        n_b_idx = r_b_idx;
        n_best = r_best;
        n_best_n = r_best_n;
        n_o_valid = 1'b0;
        n_o_upd = r_o_upd;
        n_o_sel = r_o_sel;
        n_o_val = r_o_val;
        n_o_pulse = r_o_pulse;
        n_o_rd = r_o_rd;
        n_o_err = r_o_err;

        src_we = 1'b0;
        src_wa = r_sidx[SW-1:0];
        src_ra = r_sidx[SW-1:0];
        prio_we = 1'b0;
        prio_wa = r_addr[PW-1:0];
        prio_wd = r_wdata[3:0];
        prio_ra = r_addr[PW-1:0];

        done = 1'b0;
        upd = 1'b0;
        sel = 1'b0;
        val = 12'd0;
        pulse = 1'b0;
        rd = 16'd0;
        err = 1'b0;
        issue = 1'b0;
        sidx = 9'd0;
        wd = se;
        b = r_wdata[7:0];
        wr = (r_cmd == CMD_WRITE);
        n_ok = {1'b0, r_n} < 9'(NUM_SOURCES);
        sidx_ok = r_sidx < 9'(NUM_SOURCES);
        size_bad = ((r_addr != ADDR_FAST_VEC) && (r_size != 2'd1)) ||
                   ((r_addr == ADDR_FAST_VEC) && (r_size != 2'd2));

        case (r_state)
            ST_CLR: begin
                // one entry of each memory per cycle after reset
                wd = SRC_RESET;
                src_we = r_clr_idx < CW'(NUM_SOURCES);
                src_wa = r_clr_idx[SW-1:0];
                prio_we = r_clr_idx < CW'(NUM_PRIORITY_REGS);
                prio_wa = r_clr_idx[PW-1:0];
                prio_wd = 4'd0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == CW'(CLR_N - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    n_n = i_irq_number;
                    n_lvl = i_line_level;
                    n_addr = i_address;
                    n_size = i_access_size;
                    n_wdata = i_write_data;
                    n_slot = i_priority_slot;
                    n_lt = i_level_triggered;
                    case (i_command)
                        CMD_ACK: sidx = {1'b0, r_cur};
                        CMD_READ, CMD_WRITE: begin
                            if (i_address < ADDR_EN_BASE) begin
                                sidx = {1'b0, i_address[7:0]};
                            end else begin
                                sidx = SENSE_SRC_OFFSET + {4'd0, i_address[4:0]};
                            end
                        end
                        default: sidx = {1'b0, i_irq_number};
                    endcase
                    n_sidx = sidx;
                    src_ra = sidx[SW-1:0];
                    prio_ra = i_address[PW-1:0];
                    n_state = ST_RD1;
                end
            end
            ST_RD1: begin
                done = 1'b1;
                case (r_cmd)
                    CMD_LINE: begin
                        if (n_ok) begin
                            case (se.sense)
                                MODE_LEVEL: issue = r_lvl;
                                MODE_FALL:  issue = !r_lvl && se.last;
                                MODE_RISE:  issue = r_lvl && !se.last;
                                default:    issue = r_lvl ^ se.last;
                            endcase
                            wd.last = r_lvl;
                            src_we = 1'b1;
                            if (!issue && (se.sense == MODE_LEVEL)) begin
                                wd.pending = 1'b0;
                                if (r_req_valid && (r_cur == r_n)) begin
                                    upd = 1'b1;
                                    sel = fast_sel(r_fv_en, r_fv_lo, r_n);
                                    n_req_valid = 1'b0;
                                end
                            end else if (issue) begin
                                wd.pending = 1'b1;
                                if ((r_n != 8'd0) && en_bit && !r_req_valid) begin
                                    n_req_valid = 1'b1;
                                    n_cur = r_n;
                                    prio_ra = se.slot[PW-1:0];
                                    n_pslot_ok = {1'b0, se.slot} < 9'(NUM_PRIORITY_REGS);
                                    done = 1'b0;
                                    n_state = ST_RD2;
                                end
                            end
                        end
                    end
                    CMD_ACK: begin
                        if (r_req_valid) begin
                            n_req_valid = 1'b0;
                            if (se.sense != MODE_LEVEL) begin
                                wd.pending = 1'b0;
                                src_we = 1'b1;
                            end
                            n_scan_idx = '0;
                            n_best = 4'd0;
                            n_best_n = '0;
                            done = 1'b0;
                            n_state = ST_SCAN;
                        end
                    end
                    CMD_READ, CMD_WRITE: begin
                        if (size_bad) begin
                            err = 1'b1;
                        end else if (r_addr < ADDR_TE_BASE) begin
                            if (sidx_ok) begin
                                if (wr) begin
                                    if ((se.sense != MODE_LEVEL) && (b == 8'd0)) begin
                                        wd.pending = 1'b0;
                                        src_we = 1'b1;
                                    end
                                end else begin
                                    rd = {15'd0, se.pending};
                                end
                            end
                        end else if (r_addr < ADDR_EN_BASE) begin
                            if (sidx_ok) begin
                                if (wr) begin
                                    wd.te = b[0];
                                    src_we = 1'b1;
                                end else begin
                                    rd = {15'd0, se.te};
                                end
                            end
                        end else if (r_addr <= ADDR_EN_LAST) begin
                            if (wr) n_en[r_addr[4:0]] = b;
                            else rd = {8'd0, en_byte};
                        end else if (r_addr == ADDR_SWI) begin
                            pulse = wr && b[0];
                        end else if (r_addr == ADDR_FAST_VEC) begin
                            if (wr) begin
                                n_fv_en = r_wdata[15];
                                n_fv_lo = b;
                            end else begin
                                rd = {r_fv_en, 7'd0, r_fv_lo};
                            end
                        end else if ((r_addr >= ADDR_PRI_BASE) && (r_addr <= ADDR_PRI_LAST)) begin
                            if ({1'b0, r_addr[7:0]} < 9'(NUM_PRIORITY_REGS)) begin
                                if (wr) prio_we = 1'b1;
                                else rd = {12'd0, pe};
                            end
                        end else if (r_addr inside {ADDR_DMA0, ADDR_DMA1, ADDR_DMA2, ADDR_DMA3})
                        begin
                            if (wr) n_dma[r_addr[3:2]] = b;
                            else rd = {8'd0, r_dma[r_addr[3:2]]};
                        end else if ((r_addr >= ADDR_SENSE_BASE) &&
                                     (r_addr <= ADDR_SENSE_LAST)) begin
                            if (sidx_ok) begin
                                if (wr) begin
                                    wd.sense = b[3:2];
                                    src_we = 1'b1;
                                end else begin
                                    rd = {12'd0, se.sense, 2'd0};
                                end
                            end
                        end else if (r_addr == ADDR_NMI_STAT) begin
                            err = wr;
                        end else if (r_addr == ADDR_NMI_RSV) begin
                            rd = 16'd0;
                        end else if (r_addr == ADDR_NMI_EN) begin
                            if (wr) n_nmi_en = r_nmi_en | b[2:0];
                            else rd = {13'd0, r_nmi_en};
                        end else if (r_addr == ADDR_NMI_MODE) begin
                            if (wr) begin
                                if (!r_nmi_en[0]) n_nmi_mode = b[3];
                            end else begin
                                rd = {12'd0, r_nmi_mode, 3'd0};
                            end
                        end else begin
                            err = 1'b1;
                        end
                        if (err && !wr) rd = 16'hffff;
                    end
                    CMD_SETUP: begin
                        if (n_ok) begin
                            wd.slot = r_slot;
                            wd.sense = r_lt ? MODE_LEVEL : MODE_RISE;
                            src_we = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RD2: begin
                done = 1'b1;
                upd = 1'b1;
                sel = fast_sel(r_fv_en, r_fv_lo, r_cur);
                val = {(r_pslot_ok ? pe : 4'd0), r_cur};
            end
            ST_SCAN: begin
                // stage a: source read
                src_ra = r_scan_idx[SW-1:0];
                if (r_scan_idx < (SW+1)'(NUM_SOURCES)) begin
                    n_a_vld = 1'b1;
                    n_a_idx = r_scan_idx[SW-1:0];
                    n_scan_idx = r_scan_idx + 1'b1;
                end
                // stage b: priority read for pending sources
                prio_ra = se.slot[PW-1:0];
                if (r_a_vld) begin
                    n_b_vld = se.pending && ({1'b0, se.slot} < 9'(NUM_PRIORITY_REGS));
                    n_b_idx = r_a_idx;
                end
                // stage c: keep the first strictly higher priority
                if (r_b_vld && (pe > r_best)) begin
                    n_best = pe;
                    n_best_n = r_b_idx;
                end
                if ((r_scan_idx == (SW+1)'(NUM_SOURCES)) && !r_a_vld && !r_b_vld) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                done = 1'b1;
                if ((r_best != 4'd0) && (r_best_n != '0) && en_bit) begin
                    upd = 1'b1;
                    sel = fast_sel(r_fv_en, r_fv_lo, 8'(r_best_n));
                    val = {r_best, 8'(r_best_n)};
                    n_req_valid = 1'b1;
                    n_cur = 8'(r_best_n);
                end
            end
            default: n_state = ST_IDLE;
        endcase

        src_wd = wd;

        if (done) begin
            n_o_valid = 1'b1;
            n_o_upd = upd;
            n_o_sel = sel;
            n_o_val = val;
            n_o_pulse = pulse;
            n_o_rd = rd;
            n_o_err = err;
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_we) src_mem[src_wa] <= src_wd;
        r_src_q <= src_mem[src_ra];
        if (prio_we) prio_mem[prio_wa] <= prio_wd;
        r_prio_q <= prio_mem[prio_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr_idx <= '0;
            r_req_valid <= 1'b0;
            r_cur <= 8'd0;
            r_fv_en <= 1'b0;
            r_fv_lo <= 8'd0;
            r_nmi_en <= 3'd0;
            r_nmi_mode <= 1'b0;
            for (int i = 0; i < 4; i++) r_dma[i] <= 8'd0;
            for (int i = 0; i < 32; i++) r_en[i] <= 8'd0;
            r_scan_idx <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr_idx <= n_clr_idx;
            r_req_valid <= n_req_valid;
            r_cur <= n_cur;
            r_fv_en <= n_fv_en;
            r_fv_lo <= n_fv_lo;
            r_nmi_en <= n_nmi_en;
            r_nmi_mode <= n_nmi_mode;
            r_dma <= n_dma;
            r_en <= n_en;
            r_scan_idx <= n_scan_idx;
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_n <= n_n;
        r_lvl <= n_lvl;
        r_addr <= n_addr;
        r_size <= n_size;
        r_wdata <= n_wdata;
        r_slot <= n_slot;
        r_lt <= n_lt;
        r_sidx <= n_sidx;
        r_pslot_ok <= n_pslot_ok;
        r_a_idx <= n_a_idx;
        r_b_idx <= n_b_idx;
        r_best <= n_best;
        r_best_n <= n_best_n;
        r_o_upd <= n_o_upd;
        r_o_sel <= n_o_sel;
        r_o_val <= n_o_val;
        r_o_pulse <= n_o_pulse;
        r_o_rd <= n_o_rd;
        r_o_err <= n_o_err;
    end

    assign busy = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;
    assign o_line_update = r_o_upd;
    assign o_line_select = r_o_sel;
    assign o_line_value = r_o_val;
    assign o_soft_pulse = r_o_pulse;
    assign o_read_data = r_o_rd;
    assign o_access_error = r_o_err;

    `PIC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not go busy")
    `PIC_ASSERT_NOW(a_sel_needs_upd, o_valid && o_line_select, o_line_update,
                    "fast line selected without a line update")
    `PIC_ASSERT_NOW(a_req_nonzero, r_req_valid, r_cur != 8'd0,
                    "outstanding request names source zero")
    `PIC_ASSERT_NOW(a_drive_has_req, o_valid && o_line_update && (o_line_value != 12'd0),
                    r_req_valid, "line driven without an outstanding request")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pic_pkg::*;

    localparam int          NSRC           = 256;
    localparam int          NPRI           = 144;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          DRAIN_CYCLES   = 300;
    localparam logic [10:0] ADDR_PEND_BASE = 11'h000;
    localparam int          RANDOM_ITEMS   = 830;

    typedef struct {
        logic [2:0]  command;
        logic [7:0]  irq_number;
        logic        line_level;
        logic [10:0] address;
        logic [1:0]  access_size;
        logic [15:0] write_data;
        logic [7:0]  priority_slot;
        logic        level_triggered;
    } cmd_item_t;

    typedef struct {
        logic        line_update;
        logic        line_select;
        logic [11:0] line_value;
        logic        soft_pulse;
        logic [15:0] read_data;
        logic        access_error;
    } response_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_command = '0;
    logic [7:0]  i_irq_number = '0;
    logic        i_line_level = 1'b0;
    logic [10:0] i_address = '0;
    logic [1:0]  i_access_size = '0;
    logic [15:0] i_write_data = '0;
    logic [7:0]  i_priority_slot = '0;
    logic        i_level_triggered = 1'b0;
    logic        o_valid;
    logic        o_line_update;
    logic        o_line_select;
    logic [11:0] o_line_value;
    logic        o_soft_pulse;
    logic [15:0] o_read_data;
    logic        o_access_error;

    priority_interrupt_controller_core dut (.*);

    always #10 i_clk = ~i_clk;

    // controller state as predicted
    logic        pend     [NSRC];
    logic [7:0]  en_byte  [32];
    logic [3:0]  pri_reg  [NPRI];
    logic [7:0]  slot_of  [NSRC];
    logic [1:0]  sense    [NSRC];
    logic        last_lvl [NSRC];
    logic        te_bit   [NSRC];
    logic [7:0]  dma_sel  [4];
    logic [15:0] fast_vec;
    logic [7:0]  cur_src;
    logic        cur_valid;
    logic [2:0]  nmi_en;
    logic [7:0]  nmi_md;

    response_t   pred;
    response_t   expected_responses[$];
    int          error_count = 0;
    int          cycle_count = 0;

    function automatic logic [3:0] prio_of(logic [7:0] n);
        return (slot_of[n] < NPRI) ? pri_reg[slot_of[n]] : 4'd0;
    endfunction

    function automatic void drive_line(logic [7:0] n, logic [11:0] v);
        pred.line_update = 1'b1;
        pred.line_select = fast_vec[15] && (fast_vec[7:0] == n);
        pred.line_value  = v;
    endfunction

    function automatic void try_request(logic [7:0] n);
        if (n != 0 && en_byte[n[7:3]][n[2:0]] && !cur_valid) begin
            cur_valid = 1'b1;
            cur_src   = n;
            drive_line(n, {prio_of(n), n});
        end
    endfunction

    function automatic void line_change(logic [7:0] n, logic lvl);
        logic issue;
        case (sense[n])
            MODE_LEVEL: issue = lvl;
            MODE_FALL:  issue = !lvl && last_lvl[n];
            MODE_RISE:  issue = lvl && !last_lvl[n];
            default:    issue = lvl ^ last_lvl[n];
        endcase
        last_lvl[n] = lvl;
        if (!issue && sense[n] == MODE_LEVEL) begin
            pend[n] = 1'b0;
            if (cur_valid && cur_src == n) begin
                drive_line(n, 12'd0);
                cur_valid = 1'b0;
            end
        end else if (issue) begin
            pend[n] = 1'b1;
            try_request(n);
        end
    endfunction

    function automatic void acknowledge();
        logic [3:0] best;
        logic [7:0] pick;
        logic       found;
        if (!cur_valid) return;
        cur_valid = 1'b0;
        if (sense[cur_src] != MODE_LEVEL) pend[cur_src] = 1'b0;
        best  = 4'd0;
        pick  = 8'd0;
        found = 1'b0;
        for (int i = 0; i < NSRC; i++) begin
            if (pend[i] && prio_of(8'(i)) > best) begin
                best  = prio_of(8'(i));
                pick  = 8'(i);
                found = 1'b1;
            end
        end
        if (found) try_request(pick);
    endfunction

    // returns 1 for a valid access
    function automatic logic bus_access(cmd_item_t it, logic wr, output logic [15:0] rd);
        logic [10:0] a;
        logic [7:0]  r;
        logic [7:0]  b;
        logic [7:0]  s;
        a  = it.address;
        r  = a[7:0];
        b  = it.write_data[7:0];
        s  = 8'(SENSE_SRC_OFFSET + {1'b0, r});
        rd = 16'd0;
        if ((a != ADDR_FAST_VEC && it.access_size != 2'd1) ||
            (a == ADDR_FAST_VEC && it.access_size != 2'd2)) return 1'b0;
        if (a < ADDR_TE_BASE) begin
            if (wr) begin
                if (sense[r] != MODE_LEVEL && b == 8'd0) pend[r] = 1'b0;
            end else rd = {15'd0, pend[r]};
        end else if (a < ADDR_EN_BASE) begin
            if (wr) te_bit[r] = b[0];
            else rd = {15'd0, te_bit[r]};
        end else if (a <= ADDR_EN_LAST) begin
            if (wr) en_byte[r[4:0]] = b;
            else rd = {8'd0, en_byte[r[4:0]]};
        end else if (a == ADDR_SWI) begin
            if (wr && b[0]) pred.soft_pulse = 1'b1;
        end else if (a == ADDR_FAST_VEC) begin
            if (wr) fast_vec = it.write_data & 16'h80ff;
            else rd = fast_vec;
        end else if (a >= ADDR_PRI_BASE && a <= ADDR_PRI_LAST) begin
            if (r >= NPRI) return 1'b1;
            if (wr) pri_reg[r] = b[3:0];
            else rd = {12'd0, pri_reg[r]};
        end else if (a == ADDR_DMA0 || a == ADDR_DMA1 || a == ADDR_DMA2 || a == ADDR_DMA3) begin
            if (wr) dma_sel[r[3:2]] = b;
            else rd = {8'd0, dma_sel[r[3:2]]};
        end else if (a >= ADDR_SENSE_BASE && a <= ADDR_SENSE_LAST) begin
            if (wr) sense[s] = b[3:2];
            else rd = {12'd0, sense[s], 2'b00};
        end else if (a == ADDR_NMI_STAT) begin
            if (wr) return 1'b0;
        end else if (a == ADDR_NMI_RSV) begin
        end else if (a == ADDR_NMI_EN) begin
            if (wr) nmi_en = nmi_en | b[2:0];
            else rd = {13'd0, nmi_en};
        end else if (a == ADDR_NMI_MODE) begin
            if (wr) begin
                if (!nmi_en[0]) nmi_md = b & 8'h08;
            end else rd = {8'd0, nmi_md};
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_response(cmd_item_t it);
        logic [15:0] rd;
        logic        ok;
        pred = '{default: '0};
        case (it.command)
            CMD_LINE:  line_change(it.irq_number, it.line_level);
            CMD_ACK:   acknowledge();
            CMD_READ, CMD_WRITE: begin
                ok = bus_access(it, it.command == CMD_WRITE, rd);
                if (!ok) begin
                    pred.access_error = 1'b1;
                    if (it.command == CMD_READ) pred.read_data = 16'hffff;
                end else if (it.command == CMD_READ) pred.read_data = rd;
            end
            CMD_SETUP: begin
                slot_of[it.irq_number] = it.priority_slot;
                sense[it.irq_number]   = it.level_triggered ? MODE_LEVEL : MODE_RISE;
            end
            default: ;
        endcase
        expected_responses.push_back(pred);
    endfunction

    function automatic void reset_prediction();
        for (int i = 0; i < NSRC; i++) begin
            pend[i] = 1'b0; slot_of[i] = 8'd0; sense[i] = MODE_RISE; last_lvl[i] = 1'b0;
            te_bit[i] = 1'b0;
        end
        for (int i = 0; i < 32; i++) en_byte[i] = 8'd0;
        for (int i = 0; i < NPRI; i++) pri_reg[i] = 4'd0;
        for (int i = 0; i < 4; i++) dma_sel[i] = 8'd0;
        fast_vec = 16'd0; cur_src = 8'd0; cur_valid = 1'b0; nmi_en = 3'd0; nmi_md = 8'd0;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // response checker
    always @(posedge i_clk) begin
        response_t e;
        if (i_rst_n && o_valid) begin
            if (expected_responses.size() == 0) begin
                $display("%0t unexpected response", $time);
                error_count++;
            end else begin
                e = expected_responses.pop_front();
                if (o_line_update !== e.line_update) begin
                    $display("%0t line_update exp %0h got %0h", $time, e.line_update, o_line_update);
                    error_count++;
                end
                if (o_line_select !== e.line_select) begin
                    $display("%0t line_select exp %0h got %0h", $time, e.line_select, o_line_select);
                    error_count++;
                end
                if (o_line_value !== e.line_value) begin
                    $display("%0t line_value exp %0h got %0h", $time, e.line_value, o_line_value);
                    error_count++;
                end
                if (o_soft_pulse !== e.soft_pulse) begin
                    $display("%0t soft_pulse exp %0h got %0h", $time, e.soft_pulse, o_soft_pulse);
                    error_count++;
                end
                if (o_read_data !== e.read_data) begin
                    $display("%0t read_data exp %0h got %0h", $time, e.read_data, o_read_data);
                    error_count++;
                end
                if (o_access_error !== e.access_error) begin
                    $display("%0t access_error exp %0h got %0h", $time, e.access_error,
                             o_access_error);
                    error_count++;
                end
            end
        end
    end

    // called just after a falling edge; leaves start high for a following transfer
    task automatic send_item(cmd_item_t it);
        logic accepted;
        i_command         = it.command;
        i_irq_number      = it.irq_number;
        i_line_level      = it.line_level;
        i_address         = it.address;
        i_access_size     = it.access_size;
        i_write_data      = it.write_data;
        i_priority_slot   = it.priority_slot;
        i_level_triggered = it.level_triggered;
        start             = 1'b1;
        accepted          = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = !busy;
        end
        predict_response(it);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (expected_responses.size() != 0) @(negedge i_clk);
    endtask

    function automatic cmd_item_t rand_item();
        cmd_item_t it;
        it.command         = 3'($urandom_range(0, 7));
        it.irq_number      = 8'($urandom);
        it.line_level      = 1'($urandom);
        it.address         = 11'($urandom);
        it.access_size     = 2'($urandom);
        it.write_data      = 16'($urandom);
        it.priority_slot   = 8'($urandom);
        it.level_triggered = 1'($urandom);
        return it;
    endfunction

    function automatic cmd_item_t mk(logic [2:0] c, logic [7:0] n, logic lvl, logic [10:0] a,
                                     logic [1:0] sz, logic [15:0] d, logic [7:0] sl, logic lt);
        cmd_item_t it;
        it = rand_item();
        it.command = c;
        it.irq_number = n; it.line_level = lvl; it.address = a; it.access_size = sz;
        it.write_data = d; it.priority_slot = sl; it.level_triggered = lt;
        return it;
    endfunction

    function automatic cmd_item_t bus(logic [2:0] c, logic [10:0] a, logic [1:0] sz,
                                      logic [15:0] d);
        return mk(c, 8'($urandom), 1'($urandom), a, sz, d, 8'($urandom), 1'($urandom));
    endfunction

    function automatic cmd_item_t line(logic [7:0] n, logic lvl);
        return mk(CMD_LINE, n, lvl, 11'($urandom), 2'($urandom), 16'($urandom), 8'($urandom),
                  1'($urandom));
    endfunction

    function automatic cmd_item_t setup(logic [7:0] n, logic [7:0] sl, logic lt);
        return mk(CMD_SETUP, n, 1'($urandom), 11'($urandom), 2'($urandom), 16'($urandom),
                  sl, lt);
    endfunction

    function automatic cmd_item_t ack();
        cmd_item_t it;
        it = rand_item();
        it.command = CMD_ACK;
        return it;
    endfunction

    task automatic test_register_map();
        send_item(bus(CMD_READ, ADDR_PEND_BASE, 2'd1, 16'h0));
        send_item(bus(CMD_WRITE, ADDR_SWI, 2'd1, 16'h0001));
        send_item(bus(CMD_WRITE, ADDR_NMI_STAT, 2'd1, 16'h00ff));
        send_item(bus(CMD_READ, 11'h7ff, 2'd1, 16'h0));
        send_item(bus(CMD_READ, ADDR_FAST_VEC, 2'd1, 16'h0));
        send_item(bus(CMD_READ, ADDR_EN_BASE, 2'd3, 16'h0));
        send_item(bus(CMD_WRITE, ADDR_NMI_EN, 2'd1, 16'hffff));
        send_item(bus(CMD_WRITE, ADDR_NMI_MODE, 2'd1, 16'hffff));
        send_item(bus(CMD_READ, ADDR_NMI_MODE, 2'd1, 16'h0));
        send_item(bus(CMD_WRITE, ADDR_SENSE_BASE + 11'd8, 2'd1, 16'h000c));
        send_item(bus(CMD_READ, ADDR_SENSE_BASE + 11'd8, 2'd1, 16'h0));
        send_item(bus(CMD_WRITE, ADDR_DMA3, 2'd1, 16'h00a5));
        send_item(bus(CMD_READ, ADDR_DMA3, 2'd1, 16'h0));
        send_item(bus(CMD_WRITE, ADDR_TE_BASE + 11'hff, 2'd1, 16'h0001));
        send_item(mk(3'd7, 8'hff, 1'b1, 11'h7ff, 2'd3, 16'hffff, 8'hff, 1'b1));
        wait_drained();
    endtask

    task automatic test_line_and_ack();
        send_item(bus(CMD_WRITE, ADDR_EN_BASE, 2'd1, 16'h00ff));
        send_item(bus(CMD_WRITE, ADDR_PRI_BASE + 11'd1, 2'd1, 16'hffff));
        send_item(setup(8'd5, 8'd1, 1'b0));
        send_item(setup(8'd6, 8'd200, 1'b1));
        send_item(line(8'd5, 1'b1));
        send_item(line(8'd6, 1'b1));
        send_item(ack());
        send_item(ack());
        send_item(line(8'd0, 1'b1));
        send_item(bus(CMD_WRITE, ADDR_FAST_VEC, 2'd2, 16'hffff & 16'h8005));
        send_item(line(8'd5, 1'b0));
        send_item(line(8'd5, 1'b1));
        send_item(bus(CMD_WRITE, ADDR_PEND_BASE + 11'd6, 2'd1, 16'h0000));
        send_item(line(8'd6, 1'b0));
        send_item(ack());
        wait_drained();
    endtask

    function automatic logic [7:0] pick_source();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2) return 8'($urandom_range(0, 15));
        if (r == 2) return 8'($urandom_range(64, 95));
        return 8'($urandom);
    endfunction

    function automatic cmd_item_t random_traffic_item();
        int r;
        cmd_item_t it;
        r = $urandom_range(0, 99);
        if (r < 30) it = line(pick_source(), 1'($urandom));
        else if (r < 42) it = ack();
        else if (r < 50) it = bus(CMD_WRITE, ADDR_PRI_BASE + 11'($urandom_range(0, 15)), 2'd1,
                                  16'($urandom));
        else if (r < 54) it = bus(CMD_WRITE, ADDR_EN_BASE + 11'($urandom_range(0, 31)), 2'd1,
                                  ($urandom_range(0, 3) != 0) ? 16'h00ff : 16'($urandom));
        else if (r < 57) it = bus(CMD_WRITE, ADDR_FAST_VEC, 2'd2, {1'b1, 7'($urandom),
                                  8'($urandom_range(0, 15))});
        else if (r < 61) it = bus(CMD_WRITE, ADDR_SENSE_BASE + 11'($urandom_range(0, 31)), 2'd1,
                                  16'($urandom));
        else if (r < 65) it = bus(CMD_WRITE, ADDR_PEND_BASE + {3'd0, pick_source()}, 2'd1,
                                  16'($urandom_range(0, 1)));
        else if (r < 75) it = bus(CMD_READ, 11'($urandom_range(0, 11'h5ff)),
                                  ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'd1,
                                  16'($urandom));
        else if (r < 85) it = setup(pick_source(),
                                    ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(0, 15)),
                                    1'($urandom));
        else if (r < 93) it = bus(3'($urandom_range(CMD_READ, CMD_WRITE)), 11'($urandom),
                                  2'($urandom), 16'($urandom));
        else it = rand_item();
        return it;
    endfunction

    task automatic test_random_traffic();
        int burst;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < 16; i++)
            send_item(bus(CMD_WRITE, ADDR_PRI_BASE + 11'(i), 2'd1, 16'($urandom)));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_item(random_traffic_item());
            if (i == RANDOM_ITEMS / 2) wait_drained();
            burst--;
            if (burst == 0) begin
                idle_cycles($urandom_range(1, 8));
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 20);
            end
        end
        wait_drained();
    endtask

    initial begin
        reset_prediction();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_register_map();
        test_line_and_ack();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && expected_responses.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/pic_pkg.sv
src/priority_interrupt_controller_core.sv
sim/tb_top.sv
